// ----- sv/motif_trellis_min_path_top_assert.svh -----
// Assertion macros shared by the trellis min-path block.
`ifndef MOTIF_TRELLIS_MIN_PATH_TOP_ASSERT_SVH
`define MOTIF_TRELLIS_MIN_PATH_TOP_ASSERT_SVH

// Condition that holds at every clock edge out of reset.
`define MTMP_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("mtmp invariant violated");

// Condition that must hold in the cycle after a trigger.
`define MTMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtmp sequence check violated");

`endif

// ----- sv/mtmp_pkg.sv -----
// Types, constants and saturating arithmetic for the trellis min-path block.
package mtmp_pkg;

    localparam int NUM_CHARS_DEF = 4;
    localparam int MAX_LEN_DEF   = 8;
    localparam int MAX_STEPS_DEF = 1024;

    localparam int COST_W   = 32;
    localparam int STATE_W  = 7;
    localparam int LEN_W    = 11;
    localparam int TIME_W   = 10;
    localparam int MINLEN_W = 4;

    localparam logic signed [COST_W-1:0] SENTINEL = 32'sh7fff_ffff;

    localparam logic MODE_COST    = 1'b0;
    localparam logic MODE_READ    = 1'b1;
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_PATH    = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_WRITE,
        ST_STEP,
        ST_FINAL,
        ST_TB_ISSUE,
        ST_TB_WAIT,
        ST_SUMMARY,
        ST_READ
    } state_t;

    // Control for the shared add-compare unit
    typedef struct packed {
        logic init;
        logic take;
        logic nonstrict;
        logic take_always;
    } acs_ctrl_t;

    function automatic logic signed [COST_W-1:0] sat_add(
        input logic signed [COST_W-1:0] a,
        input logic signed [COST_W-1:0] b
    );
        logic signed [COST_W:0] s;
        s = $signed({a[COST_W-1], a}) + $signed({b[COST_W-1], b});
        if (s[COST_W] != s[COST_W-1])
        begin
            sat_add = s[COST_W] ? {1'b1, {(COST_W-1){1'b0}}} : SENTINEL;
        end
        else
        begin
            sat_add = s[COST_W-1:0];
        end
    endfunction

endpackage

// ----- sv/motif_trellis_min_path_top.sv -----
// Top level of the trellis min-path block: sequencer, metric, backpointer and path memories.
//
// Usage: a beat is taken when start is high and busy is low. In mode 0 the beat carries
// the cost of the next trellis state; states of a column arrive in order 0..NSTATES-1
// and columns follow one another. Set end_of_sequence on the last state of the final
// column to close the sequence: the block then finds the best end state, traces the
// path back and emits one summary beat. In mode 1 the beat reads the stored path state
// at time_index and always yields one path beat. Results appear for one cycle with done
// high; the receiver cannot stall, so results are never held.
// Mode 0 beats after the first column go through one add-compare unit fed by a metric
// memory with one write and one registered read port. Unassigned and position-0 states
// sweep every state as a candidate predecessor. Closing a sequence adds a search for the
// best end state and a traceback through the backpointer memory for each column after the
// first. Results appear in the cycle in which busy drops at the end of the beat.
// Reset: min_length returns to 1, the column and state counters clear and no path is
// held. Memories need no clearing pass: every entry is written before it is read.
module motif_trellis_min_path_top #(
    parameter int NUM_CHARS = mtmp_pkg::NUM_CHARS_DEF,
    parameter int MAX_LEN   = mtmp_pkg::MAX_LEN_DEF,
    parameter int MAX_STEPS = mtmp_pkg::MAX_STEPS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [mtmp_pkg::MINLEN_W-1:0]         cfg_wdata,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  mode,
    input  logic signed [mtmp_pkg::COST_W-1:0]    cost,
    input  logic                                  end_of_sequence,
    input  logic [mtmp_pkg::TIME_W-1:0]           time_index,
    output logic                                  done,
    output logic                                  result_kind,
    output logic [mtmp_pkg::STATE_W-1:0]          state_index,
    output logic signed [mtmp_pkg::COST_W-1:0]    path_cost,
    output logic [mtmp_pkg::LEN_W-1:0]            sequence_length,
    output logic                                  read_error
);

    `include "motif_trellis_min_path_top_assert.svh"

    localparam int NS   = 2 * NUM_CHARS * MAX_LEN + 1;
    localparam int SW   = $clog2(NS);
    localparam int PSW  = $clog2(MAX_LEN);
    localparam int CW   = $clog2(MAX_STEPS + 1);
    localparam int PW   = $clog2(MAX_STEPS);
    localparam int BD   = MAX_STEPS * NS;
    localparam int BW   = $clog2(BD);
    localparam int BBW  = $clog2(BD + 1);
    localparam int MD   = 2 * NS;
    localparam int MW   = $clog2(MD);
    localparam int CMPW = (PSW + 1 > mtmp_pkg::MINLEN_W) ? PSW + 2 : mtmp_pkg::MINLEN_W + 1;
    localparam int XW   = (CW > mtmp_pkg::TIME_W) ? CW + 1 : mtmp_pkg::TIME_W + 1;

    localparam logic [SW-1:0]  LAST_S    = SW'(NS - 1);
    localparam logic [PSW-1:0] LAST_POS  = PSW'(MAX_LEN - 1);
    localparam logic [CW-1:0]  STEPS_MAX = CW'(MAX_STEPS);
    localparam logic [BBW-1:0] NS_B      = BBW'(NS);
    localparam logic [MW-1:0]  NS_M      = MW'(NS);

    // Memories
    logic signed [mtmp_pkg::COST_W-1:0] met_mem [0:MD-1];
    logic [SW-1:0]                      bp_mem  [0:BD-1];
    logic [SW-1:0]                      ps_mem  [0:MAX_STEPS-1];

    logic                               met_we;
    logic [MW-1:0]                      met_waddr;
    logic signed [mtmp_pkg::COST_W-1:0] met_wdata;
    logic [MW-1:0]                      met_raddr;
    logic signed [mtmp_pkg::COST_W-1:0] met_rdata;
    logic                               bp_we;
    logic [BW-1:0]                      bp_waddr;
    logic [SW-1:0]                      bp_wdata;
    logic [BW-1:0]                      bp_raddr;
    logic [SW-1:0]                      bp_rdata;
    logic                               ps_we;
    logic [PW-1:0]                      ps_waddr;
    logic [SW-1:0]                      ps_wdata;
    logic [PW-1:0]                      ps_raddr;
    logic [SW-1:0]                      ps_rdata;

    // Sequencer state
    mtmp_pkg::state_t state_reg, state_next;
    logic [mtmp_pkg::MINLEN_W-1:0]      min_len_reg, min_len_next;
    logic [SW-1:0]                      s_reg, s_next;
    logic [PSW-1:0]                     s_pos_reg, s_pos_next;
    logic                               s_dig_reg, s_dig_next;
    logic [CW-1:0]                      col_reg, col_next;
    logic [BBW-1:0]                     wbase_reg, wbase_next;
    logic                               bank_reg, bank_next;
    logic signed [mtmp_pkg::COST_W-1:0] cost_reg, cost_next;
    logic                               eos_reg, eos_next;
    logic                               drop_reg, drop_next;
    logic                               fin_reg, fin_next;
    logic                               direct_reg, direct_next;
    logic signed [mtmp_pkg::COST_W-1:0] dval_reg, dval_next;
    logic [SW-1:0]                      p_reg, p_next;
    logic [PSW-1:0]                     p_pos_reg, p_pos_next;
    logic                               p_dig_reg, p_dig_next;
    logic [SW-1:0]                      p_last_reg, p_last_next;
    logic                               sweep_all_reg, sweep_all_next;
    logic                               pv_reg, pv_next;
    logic                               pn_reg, pn_next;
    logic                               pf_reg, pf_next;
    logic [SW-1:0]                      pp_reg, pp_next;
    logic [CW-1:0]                      tb_t_reg, tb_t_next;
    logic [SW-1:0]                      tb_cur_reg, tb_cur_next;
    logic [BBW-1:0]                     tb_base_reg, tb_base_next;
    logic [SW-1:0]                      fin_s_reg, fin_s_next;
    logic                               path_valid_reg, path_valid_next;
    logic [CW-1:0]                      path_len_reg, path_len_next;
    logic signed [mtmp_pkg::COST_W-1:0] pcost_reg, pcost_next;
    logic                               rd_ok_reg, rd_ok_next;

    // Result beat
    logic                               done_reg, done_next;
    logic                               kind_reg, kind_next;
    logic [mtmp_pkg::STATE_W-1:0]       sidx_reg, sidx_next;
    logic signed [mtmp_pkg::COST_W-1:0] ocost_reg, ocost_next;
    logic [mtmp_pkg::LEN_W-1:0]         slen_reg, slen_next;
    logic                               rerr_reg, rerr_next;

    // Add-compare unit
    mtmp_pkg::acs_ctrl_t                acs_ctrl;
    logic                               acs_init;
    logic signed [mtmp_pkg::COST_W-1:0] acs_best;
    logic [SW-1:0]                      acs_bp;

    logic [mtmp_pkg::MINLEN_W-1:0]      lmin_eff;
    logic                               p_is_end;
    logic                               s_is_start;

    assign lmin_eff   = (min_len_reg == '0) ? mtmp_pkg::MINLEN_W'(1) : min_len_reg;
    assign p_is_end   = (p_reg != '0) &&
                        ((CMPW'(p_pos_reg) + CMPW'(1)) >= CMPW'(lmin_eff));
    assign s_is_start = (s_reg == '0) || (s_pos_reg == '0);

    assign acs_ctrl.init        = acs_init;
    assign acs_ctrl.take        = pv_reg;
    assign acs_ctrl.nonstrict   = pn_reg;
    assign acs_ctrl.take_always = pf_reg;

    mtmp_acs #(
        .SW(SW)
    ) u_acs (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (acs_ctrl),
        .metric (met_rdata),
        .cost   (cost_reg),
        .pred   (pp_reg),
        .best   (acs_best),
        .bp     (acs_bp)
    );

    // Next state and outputs of the sequencer
    always_comb
    begin
        state_next     = state_reg;
        min_len_next   = cfg_we ? cfg_wdata : min_len_reg;
        s_next         = s_reg;
        s_pos_next     = s_pos_reg;
        s_dig_next     = s_dig_reg;
        col_next       = col_reg;
        wbase_next     = wbase_reg;
        bank_next      = bank_reg;
        cost_next      = cost_reg;
        eos_next       = eos_reg;
        drop_next      = drop_reg;
        fin_next       = fin_reg;
        direct_next    = direct_reg;
        dval_next      = dval_reg;
        p_next         = p_reg;
        p_pos_next     = p_pos_reg;
        p_dig_next     = p_dig_reg;
        p_last_next    = p_last_reg;
        sweep_all_next = sweep_all_reg;
        pv_next        = 1'b0;
        pn_next        = 1'b0;
        pf_next        = 1'b0;
        pp_next        = pp_reg;
        tb_t_next      = tb_t_reg;
        tb_cur_next    = tb_cur_reg;
        tb_base_next   = tb_base_reg;
        fin_s_next     = fin_s_reg;
        path_valid_next = path_valid_reg;
        path_len_next  = path_len_reg;
        pcost_next     = pcost_reg;
        rd_ok_next     = rd_ok_reg;
        done_next      = 1'b0;
        kind_next      = kind_reg;
        sidx_next      = sidx_reg;
        ocost_next     = ocost_reg;
        slen_next      = slen_reg;
        rerr_next      = rerr_reg;
        acs_init       = 1'b0;
        met_we         = 1'b0;
        met_waddr      = '0;
        met_wdata      = acs_best;
        met_raddr      = '0;
        bp_we          = 1'b0;
        bp_waddr       = '0;
        bp_wdata       = acs_bp;
        bp_raddr       = '0;
        ps_we          = 1'b0;
        ps_waddr       = '0;
        ps_wdata       = acs_bp;
        ps_raddr       = PW'(time_index);

        unique case (state_reg)
            mtmp_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (mode == mtmp_pkg::MODE_READ)
                    begin
                        rd_ok_next = path_valid_reg &&
                                     (XW'(time_index) < XW'(path_len_reg));
                        state_next = mtmp_pkg::ST_READ;
                    end
                    else
                    begin
                        cost_next = cost;
                        eos_next  = end_of_sequence;
                        fin_next  = 1'b0;
                        drop_next = (col_reg >= STEPS_MAX);
                        if (col_reg >= STEPS_MAX)
                        begin
                            state_next = mtmp_pkg::ST_STEP;
                        end
                        else if (col_reg == '0)
                        begin
                            direct_next = 1'b1;
                            dval_next   = s_is_start ? cost : mtmp_pkg::SENTINEL;
                            state_next  = mtmp_pkg::ST_WRITE;
                        end
                        else
                        begin
                            direct_next = 1'b0;
                            acs_init    = 1'b1;
                            if (s_is_start)
                            begin
                                p_next         = '0;
                                p_pos_next     = '0;
                                p_dig_next     = 1'b0;
                                p_last_next    = LAST_S;
                                sweep_all_next = 1'b1;
                            end
                            else
                            begin
                                p_next         = s_reg - SW'(2) - SW'(s_dig_reg);
                                p_last_next    = s_reg - SW'(1) - SW'(s_dig_reg);
                                sweep_all_next = 1'b0;
                            end
                            state_next = mtmp_pkg::ST_SWEEP;
                        end
                    end
                end
            end

            mtmp_pkg::ST_SWEEP:
            begin
                // Issue one predecessor read a cycle; the compare uses the registered read data
                met_raddr = bank_reg ? (NS_M + MW'(p_reg)) : MW'(p_reg);
                pp_next   = p_reg;
                pv_next   = sweep_all_reg ? ((p_reg == '0) || p_is_end) : 1'b1;
                pn_next   = sweep_all_reg && !fin_reg && (s_reg != '0) && (p_reg != '0);
                pf_next   = fin_reg && (p_reg == '0);
                // Advance the candidate index and its position
                p_next = p_reg + SW'(1);
                if (p_reg == '0)
                begin
                    p_pos_next = '0;
                    p_dig_next = 1'b0;
                end
                else if (!p_dig_reg)
                begin
                    p_dig_next = 1'b1;
                end
                else
                begin
                    p_dig_next = 1'b0;
                    p_pos_next = (p_pos_reg == LAST_POS) ? '0 : p_pos_reg + PSW'(1);
                end
                if (p_reg == p_last_reg)
                begin
                    state_next = mtmp_pkg::ST_DRAIN;
                end
            end

            mtmp_pkg::ST_DRAIN:
            begin
                state_next = fin_reg ? mtmp_pkg::ST_FINAL : mtmp_pkg::ST_WRITE;
            end

            mtmp_pkg::ST_WRITE:
            begin
                // Store this state's metric and backpointer
                met_we    = 1'b1;
                met_waddr = bank_reg ? MW'(s_reg) : (NS_M + MW'(s_reg));
                met_wdata = direct_reg ? dval_reg : acs_best;
                bp_we     = 1'b1;
                bp_waddr  = BW'(wbase_reg + BBW'(s_reg));
                bp_wdata  = direct_reg ? '0 : acs_bp;
                state_next = mtmp_pkg::ST_STEP;
            end

            mtmp_pkg::ST_STEP:
            begin
                if (s_reg == LAST_S)
                begin
                    s_next = '0;
                    if (!drop_reg)
                    begin
                        bank_next  = !bank_reg;
                        col_next   = col_reg + CW'(1);
                        wbase_next = wbase_reg + NS_B;
                    end
                    if (eos_reg)
                    begin
                        // Search end states of the last column
                        fin_next       = 1'b1;
                        cost_next      = '0;
                        acs_init       = 1'b1;
                        p_next         = '0;
                        p_pos_next     = '0;
                        p_dig_next     = 1'b0;
                        p_last_next    = LAST_S;
                        sweep_all_next = 1'b1;
                        state_next     = mtmp_pkg::ST_SWEEP;
                    end
                    else
                    begin
                        state_next = mtmp_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    s_next = s_reg + SW'(1);
                    if (s_reg == '0)
                    begin
                        s_pos_next = '0;
                        s_dig_next = 1'b0;
                    end
                    else if (!s_dig_reg)
                    begin
                        s_dig_next = 1'b1;
                    end
                    else
                    begin
                        s_dig_next = 1'b0;
                        s_pos_next = (s_pos_reg == LAST_POS) ? '0 : s_pos_reg + PSW'(1);
                    end
                    state_next = mtmp_pkg::ST_IDLE;
                end
            end

            mtmp_pkg::ST_FINAL:
            begin
                pcost_next   = acs_best;
                fin_s_next   = acs_bp;
                tb_cur_next  = acs_bp;
                tb_t_next    = col_reg;
                tb_base_next = wbase_reg - NS_B;
                ps_we        = 1'b1;
                ps_waddr     = PW'(col_reg - CW'(1));
                ps_wdata     = acs_bp;
                state_next   = (col_reg >= CW'(2)) ? mtmp_pkg::ST_TB_ISSUE
                                                   : mtmp_pkg::ST_SUMMARY;
            end

            mtmp_pkg::ST_TB_ISSUE:
            begin
                bp_raddr   = BW'(tb_base_reg + BBW'(tb_cur_reg));
                state_next = mtmp_pkg::ST_TB_WAIT;
            end

            mtmp_pkg::ST_TB_WAIT:
            begin
                // Step one column back along the path
                ps_we        = 1'b1;
                ps_waddr     = PW'(tb_t_reg - CW'(2));
                ps_wdata     = bp_rdata;
                tb_cur_next  = bp_rdata;
                tb_t_next    = tb_t_reg - CW'(1);
                tb_base_next = tb_base_reg - NS_B;
                state_next   = (tb_t_reg >= CW'(3)) ? mtmp_pkg::ST_TB_ISSUE
                                                    : mtmp_pkg::ST_SUMMARY;
            end

            mtmp_pkg::ST_SUMMARY:
            begin
                done_next       = 1'b1;
                kind_next       = mtmp_pkg::KIND_SUMMARY;
                sidx_next       = mtmp_pkg::STATE_W'(fin_s_reg);
                ocost_next      = pcost_reg;
                slen_next       = mtmp_pkg::LEN_W'(col_reg);
                rerr_next       = 1'b0;
                path_valid_next = 1'b1;
                path_len_next   = col_reg;
                col_next        = '0;
                wbase_next      = '0;
                fin_next        = 1'b0;
                state_next      = mtmp_pkg::ST_IDLE;
            end

            mtmp_pkg::ST_READ:
            begin
                done_next  = 1'b1;
                kind_next  = mtmp_pkg::KIND_PATH;
                sidx_next  = rd_ok_reg ? mtmp_pkg::STATE_W'(ps_rdata) : '0;
                ocost_next = path_valid_reg ? pcost_reg : '0;
                slen_next  = path_valid_reg ? mtmp_pkg::LEN_W'(path_len_reg) : '0;
                rerr_next  = !rd_ok_reg;
                state_next = mtmp_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = mtmp_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold sequencer and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mtmp_pkg::ST_IDLE;
            min_len_reg    <= mtmp_pkg::MINLEN_W'(1);
            s_reg          <= '0;
            s_pos_reg      <= '0;
            s_dig_reg      <= 1'b0;
            col_reg        <= '0;
            wbase_reg      <= '0;
            bank_reg       <= 1'b0;
            cost_reg       <= '0;
            eos_reg        <= 1'b0;
            drop_reg       <= 1'b0;
            fin_reg        <= 1'b0;
            direct_reg     <= 1'b0;
            dval_reg       <= '0;
            p_reg          <= '0;
            p_pos_reg      <= '0;
            p_dig_reg      <= 1'b0;
            p_last_reg     <= '0;
            sweep_all_reg  <= 1'b0;
            pv_reg         <= 1'b0;
            pn_reg         <= 1'b0;
            pf_reg         <= 1'b0;
            pp_reg         <= '0;
            tb_t_reg       <= '0;
            tb_cur_reg     <= '0;
            tb_base_reg    <= '0;
            fin_s_reg      <= '0;
            path_valid_reg <= 1'b0;
            path_len_reg   <= '0;
            pcost_reg      <= '0;
            rd_ok_reg      <= 1'b0;
            done_reg       <= 1'b0;
            kind_reg       <= 1'b0;
            sidx_reg       <= '0;
            ocost_reg      <= '0;
            slen_reg       <= '0;
            rerr_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            min_len_reg    <= min_len_next;
            s_reg          <= s_next;
            s_pos_reg      <= s_pos_next;
            s_dig_reg      <= s_dig_next;
            col_reg        <= col_next;
            wbase_reg      <= wbase_next;
            bank_reg       <= bank_next;
            cost_reg       <= cost_next;
            eos_reg        <= eos_next;
            drop_reg       <= drop_next;
            fin_reg        <= fin_next;
            direct_reg     <= direct_next;
            dval_reg       <= dval_next;
            p_reg          <= p_next;
            p_pos_reg      <= p_pos_next;
            p_dig_reg      <= p_dig_next;
            p_last_reg     <= p_last_next;
            sweep_all_reg  <= sweep_all_next;
            pv_reg         <= pv_next;
            pn_reg         <= pn_next;
            pf_reg         <= pf_next;
            pp_reg         <= pp_next;
            tb_t_reg       <= tb_t_next;
            tb_cur_reg     <= tb_cur_next;
            tb_base_reg    <= tb_base_next;
            fin_s_reg      <= fin_s_next;
            path_valid_reg <= path_valid_next;
            path_len_reg   <= path_len_next;
            pcost_reg      <= pcost_next;
            rd_ok_reg      <= rd_ok_next;
            done_reg       <= done_next;
            kind_reg       <= kind_next;
            sidx_reg       <= sidx_next;
            ocost_reg      <= ocost_next;
            slen_reg       <= slen_next;
            rerr_reg       <= rerr_next;
        end
    end

    // Metric memory: two column banks, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (met_we)
        begin
            met_mem[met_waddr] <= met_wdata;
        end
        met_rdata <= met_mem[met_raddr];
    end

    // Backpointer memory
    always_ff @(posedge clk)
    begin
        if (bp_we)
        begin
            bp_mem[bp_waddr] <= bp_wdata;
        end
        bp_rdata <= bp_mem[bp_raddr];
    end

    // Path memory
    always_ff @(posedge clk)
    begin
        if (ps_we)
        begin
            ps_mem[ps_waddr] <= ps_wdata;
        end
        ps_rdata <= ps_mem[ps_raddr];
    end

    assign busy            = (state_reg != mtmp_pkg::ST_IDLE);
    assign done            = done_reg;
    assign result_kind     = kind_reg;
    assign state_index     = sidx_reg;
    assign path_cost       = ocost_reg;
    assign sequence_length = slen_reg;
    assign read_error      = rerr_reg;

    // Checks
    `MTMP_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `MTMP_ASSERT_ALWAYS(a_state_range, clk, rst_n, s_reg <= LAST_S)
    `MTMP_ASSERT_ALWAYS(a_err_state, clk, rst_n, !(done && read_error) || (state_index == '0))
    `MTMP_ASSERT_NEXT(a_summary_valid, clk, rst_n, state_reg == mtmp_pkg::ST_SUMMARY, path_valid_reg)
    `MTMP_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)

endmodule

// ----- sv/mtmp_acs.sv -----
// Shared saturating add-compare-select unit with running best and backpointer.
module mtmp_acs #(
    parameter int SW = 7
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  mtmp_pkg::acs_ctrl_t                   ctrl,
    input  logic signed [mtmp_pkg::COST_W-1:0]    metric,
    input  logic signed [mtmp_pkg::COST_W-1:0]    cost,
    input  logic [SW-1:0]                         pred,
    output logic signed [mtmp_pkg::COST_W-1:0]    best,
    output logic [SW-1:0]                         bp
);

    logic signed [mtmp_pkg::COST_W-1:0] best_reg;
    logic signed [mtmp_pkg::COST_W-1:0] best_next;
    logic [SW-1:0]                      bp_reg;
    logic [SW-1:0]                      bp_next;
    logic signed [mtmp_pkg::COST_W-1:0] sum;
    logic                               better;

    // Add candidate metric and cost, then compare against the running best; init resets it
    always_comb
    begin
        sum    = mtmp_pkg::sat_add(metric, cost);
        better = ctrl.take && (ctrl.take_always || (sum < best_reg) ||
                               (ctrl.nonstrict && (sum == best_reg)));
        best_next = best_reg;
        bp_next   = bp_reg;
        if (ctrl.init)
        begin
            best_next = mtmp_pkg::SENTINEL;
            bp_next   = '0;
        end
        else if (better)
        begin
            best_next = sum;
            bp_next   = pred;
        end
    end

    // Hold the running best
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= mtmp_pkg::SENTINEL;
            bp_reg   <= '0;
        end
        else
        begin
            best_reg <= best_next;
            bp_reg   <= bp_next;
        end
    end

    assign best = best_reg;
    assign bp   = bp_reg;

endmodule
